>>> sv/bsos_pkg.sv
// ----------------------------------------------------------------------------
// bsos_pkg: shared types and constants for the presence bitmap
// Request and response beats, request codes, and the control store of the
// step sequencer that runs each request.
// ----------------------------------------------------------------------------
`default_nettype none

package bsos_pkg;

   localparam int BITS_PER_WORD   = 1 * 4 * 8;
   localparam int BIT_W           = $clog2(BITS_PER_WORD);
   localparam int VALUE_W         = 15;
   localparam int IDX_W           = VALUE_W - BIT_W;
   localparam int VALUE_WORDS     = (2 ** VALUE_W) / BITS_PER_WORD;
   localparam int WORD_COUNT_DEF  = 1024;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TEST  = 2'd2,
      OP_FIND  = 2'd3
   } bsos_op_type;

   typedef struct packed {
      bsos_op_type          req_type;
      logic [VALUE_W-1:0]   value;
   } bsos_req_type;

   typedef struct packed {
      logic                 hit;
      logic [VALUE_W-1:0]   found_value;
   } bsos_rsp_type;

   // datapath action of one step
   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_ACCEPT = 2'd1,
      ACT_MODIFY = 2'd2,
      ACT_SCAN   = 2'd3
   } bsos_act_type;

   // how the step counter moves on
   typedef enum logic [1:0] {
      COND_ALWAYS     = 2'd0,  // go to target
      COND_CLEAR_DONE = 2'd1,  // last word cleared: next step, else target
      COND_DISPATCH   = 2'd2,  // no start: target, else by request code
      COND_SCAN_DONE  = 2'd3   // scan finished: target, else repeat step
   } bsos_cond_type;

   localparam int PC_W = 2;
   localparam int UCODE_DEPTH = 2 ** PC_W;

   localparam logic [PC_W-1:0] STEP_CLEAR = 2'd0;
   localparam logic [PC_W-1:0] STEP_IDLE  = 2'd1;
   localparam logic [PC_W-1:0] STEP_RMW   = 2'd2;
   localparam logic [PC_W-1:0] STEP_FIND  = 2'd3;

   typedef struct packed {
      bsos_act_type         act;
      bsos_cond_type        cond;
      logic [PC_W-1:0]      target;
   } bsos_ctrl_type;

   typedef struct packed {
      logic                 start;
      logic                 is_find;
      logic                 clear_last;
      logic                 scan_done;
   } bsos_flags_type;

   localparam bsos_ctrl_type UCODE [UCODE_DEPTH] = '{
      '{act: ACT_CLEAR,  cond: COND_CLEAR_DONE, target: STEP_CLEAR},
      '{act: ACT_ACCEPT, cond: COND_DISPATCH,   target: STEP_IDLE},
      '{act: ACT_MODIFY, cond: COND_ALWAYS,     target: STEP_IDLE},
      '{act: ACT_SCAN,   cond: COND_SCAN_DONE,  target: STEP_IDLE}
   };

endpackage

`default_nettype wire

>>> sv/bsos_ram.sv
// ----------------------------------------------------------------------------
// bsos_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsos_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/bsos_seq.sv
// ----------------------------------------------------------------------------
// bsos_seq: step sequencer
// Step counter over the control store; issues one control word per cycle
// and picks the next step from the jump condition and the datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bsos_seq import bsos_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bsos_flags_type  flags,
   output bsos_ctrl_type        ctrl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;

   assign ctrl = UCODE[pc_ff];

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS: begin
            pc_in = ctrl.target;
         end
         COND_CLEAR_DONE: begin
            pc_in = flags.clear_last ? pc_ff + PC_W'(1) : ctrl.target;
         end
         COND_DISPATCH: begin
            if (!flags.start) begin
               pc_in = ctrl.target;
            end else begin
               pc_in = flags.is_find ? STEP_FIND : STEP_RMW;
            end
         end
         COND_SCAN_DONE: begin
            pc_in = flags.scan_done ? ctrl.target : pc_ff;
         end
         default: begin
            pc_in = ctrl.target;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/bitmap_set_with_ordered_scan.sv
// ----------------------------------------------------------------------------
// bitmap_set_with_ordered_scan: presence bitmap with ordered scan
// Set, clear and test single values; find the smallest marked value at or
// after a start value. Repeated finds walk the marked values in order.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  request   start, busy, req_data        taken when start and not busy
//  response  rsp_valid, rsp_data          one-cycle strobe, never stalled
//
//  Set, clear and test run as a RAM read, then modify/write.
//  Find reads the start value's word, then scans words upward, 1 .. 1024 in all;
//  the single RAM read port delivers one word per cycle.
//  The response strobe is registered and rises in the cycle after the last step.
//  After reset a clearing pass writes zeros to every stored word, one per
//  cycle, min(WORD_COUNT, 1024) words in all; busy stays high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_set_with_ordered_scan import bsos_pkg::*; #(
   parameter int WORD_COUNT = WORD_COUNT_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire bsos_req_type  req_data,
   output logic               rsp_valid,
   output bsos_rsp_type       rsp_data
);

   // words above the value range can never be reached
   localparam int STORE_WORDS = (WORD_COUNT < VALUE_WORDS) ? WORD_COUNT : VALUE_WORDS;
   localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   bsos_ctrl_type   ctrl;
   bsos_flags_type  flags;

   bsos_req_type        req_ff;
   logic                in_range_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                first_ff;
   logic [ADDR_W-1:0]   clr_ff;
   logic                rsp_valid_ff;
   bsos_rsp_type        rsp_data_ff;

   bsos_req_type        req_in;
   logic                in_range_in;
   logic [IDX_W-1:0]    idx_in;
   logic                first_in;
   logic [ADDR_W-1:0]   clr_in;
   logic                rsp_valid_in;
   bsos_rsp_type        rsp_data_in;

   logic                accept;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [BITS_PER_WORD-1:0] wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [BITS_PER_WORD-1:0] rd_data;

   logic [BITS_PER_WORD-1:0] bit_mask;
   logic [BITS_PER_WORD-1:0] scan_word;
   logic [BITS_PER_WORD-1:0] low_bit;
   logic [BIT_W-1:0]         low_pos;
   logic                     scan_hit;
   logic                     idx_last;
   logic                     clear_last;

   assign busy   = (ctrl.act != ACT_ACCEPT);
   assign accept = start && !busy;

   assign bit_mask   = BITS_PER_WORD'(1) << req_ff.value[BIT_W-1:0];
   assign scan_word  = rd_data & (first_ff ? ({BITS_PER_WORD{1'b1}} <<
                                              req_ff.value[BIT_W-1:0])
                                           : {BITS_PER_WORD{1'b1}});
   assign low_bit    = scan_word & (~scan_word + BITS_PER_WORD'(1));
   assign scan_hit   = (scan_word != '0);
   assign idx_last   = (idx_ff == IDX_W'(STORE_WORDS - 1));
   assign clear_last = (clr_ff == ADDR_W'(STORE_WORDS - 1));

   // encode the isolated lowest set bit
   always_comb begin
      low_pos = '0;
      for (int i = 0; i < BITS_PER_WORD; i++) begin
         if (low_bit[i]) begin
            low_pos = low_pos | BIT_W'(i);
         end
      end
   end

   assign flags.start      = start;
   assign flags.is_find    = (req_data.req_type == OP_FIND);
   assign flags.clear_last = clear_last;
   assign flags.scan_done  = !in_range_ff || scan_hit || idx_last;

   bsos_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   bsos_ram #(
      .WIDTH (BITS_PER_WORD),
      .DEPTH (STORE_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      req_in       = req_ff;
      in_range_in  = in_range_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(idx_ff);
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(idx_ff);

      unique case (ctrl.act)
         ACT_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
         end
         ACT_ACCEPT: begin
            // latch the beat and fetch its first word
            if (accept) begin
               req_in      = req_data;
               in_range_in = 32'(req_data.value[VALUE_W-1:BIT_W]) < 32'(WORD_COUNT);
               idx_in      = req_data.value[VALUE_W-1:BIT_W];
               first_in    = 1'b1;
               rd_en       = 1'b1;
               rd_addr     = ADDR_W'(req_data.value[VALUE_W-1:BIT_W]);
            end
         end
         ACT_MODIFY: begin
            rsp_valid_in = 1'b1;
            wr_en = in_range_ff &&
                    (req_ff.req_type == OP_SET || req_ff.req_type == OP_CLEAR);
            wr_data = (req_ff.req_type == OP_SET) ? (rd_data | bit_mask)
                                                  : (rd_data & ~bit_mask);
            rsp_data_in.hit = in_range_ff && (req_ff.req_type == OP_TEST) &&
                              ((rd_data & bit_mask) != '0);
         end
         ACT_SCAN: begin
            first_in = 1'b0;
            if (flags.scan_done) begin
               rsp_valid_in = 1'b1;
               if (in_range_ff && scan_hit) begin
                  rsp_data_in.hit         = 1'b1;
                  rsp_data_in.found_value = {idx_ff, low_pos};
               end
            end else begin
               // advance to the next word
               idx_in  = idx_ff + IDX_W'(1);
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(idx_ff + IDX_W'(1));
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      in_range_ff <= in_range_in;
      idx_ff      <= idx_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after taking a request");

   a_rmw_latency: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.req_type != OP_FIND |-> ##2 rsp_valid)
      else $error("set, clear or test response missing");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while a request is still running");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.found_value == '0)
      else $error("found value not zero on a miss");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !wr_en)
      else $error("store written while idle");

endmodule

`default_nettype wire
